@@ rtl/bfm_pkg.sv @@
// Shared constants, register codes and sideband types of the brush falloff mask.
`default_nettype none

package bfm_pkg;

  // Default parameter values
  localparam int MAX_SIZE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int COORD_W    = 8;
  localparam int SZ_W       = 9;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 4'd1;

  // Reset values
  localparam logic [SZ_W-1:0]   BRUSH_SIZE_RST = 9'd16;
  localparam logic [MODE_W-1:0] SHAPE_MODE_RST = 2'd0;

  // Shape codes
  localparam logic [MODE_W-1:0] SHAPE_CIRCLE  = 2'd0;
  localparam logic [MODE_W-1:0] SHAPE_SQUARE  = 2'd1;
  localparam logic [MODE_W-1:0] SHAPE_DIAMOND = 2'd2;

  // Sideband carried alongside the coordinate dividers
  typedef struct packed {
    logic              oor;
    logic [MODE_W-1:0] mode;
  } tag_t;

  // Sideband carried through the circle datapath
  typedef struct packed {
    logic              oor;
    logic [MODE_W-1:0] mode;
    logic              dia;
    logic              in_disc;
  } ctag_t;

  // Integer square root, for elaboration-time constants only
  function automatic longint unsigned isqrt_const(longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bit_v;
    rem   = v;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfm_if.sv @@
// Handshake channels of the brush falloff mask: cell requests, results and config writes.
`default_nettype none

interface bfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfm_pkg::COORD_W-1:0]  col;
  logic [bfm_pkg::COORD_W-1:0]  row;
  modport source (output valid, col, row, input ready);
  modport sink   (input valid, col, row, output ready);
endinterface

interface bfm_out_if #(
  parameter int WEIGHT_W = bfm_pkg::FRAC_BITS_DEF + 1
);
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                out_of_range;
  modport source (output valid, weight, out_of_range, input ready);
  modport sink   (input valid, weight, out_of_range, output ready);
endinterface

interface bfm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfm_pkg::CFG_IDX_W-1:0]  index;
  logic [bfm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/brush_falloff_mask.sv @@
// Brush falloff mask: weight of one brush grid cell for circle, square or diamond shape.
//
// Channels: item carries a cell request (col, row); result returns one weight
// (unsigned, FRAC_BITS fraction bits) and an out_of_range flag for every request,
// in order. cfg writes brush_size (index 0) and shape_mode (index 1); it is always
// ready and other indexes are dropped. Write config only while the pipe is empty.
//
// Throughput: one request per clock while the output register is empty or being
// taken. The pipe depth is set by the one-bit-per-stage divider normalising the
// coordinates and the one-bit-per-stage square root, each FRAC_BITS+1 stages deep;
// the circle scaling is a one-stage multiply by a constant reciprocal.
//
// Stalls: the whole pipe, output register included, advances only when the output
// register is empty or being taken, so item.ready follows result.ready and nothing
// is dropped or duplicated.
// Reset: synchronous; clears all valid bits and loads brush_size 16, circle shape.
`default_nettype none

module brush_falloff_mask #(
  parameter int MAX_SIZE  = bfm_pkg::MAX_SIZE_DEF,
  parameter int FRAC_BITS = bfm_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bfm_cfg_if.sink       cfg,
  bfm_in_if.sink        item,
  bfm_out_if.source     result
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 1;          // weight / normalised magnitude width
  localparam int SQW = 2 * F + 2;      // squared distance / radicand width
  localparam int NW1 = bfm_pkg::SZ_W + F;
  localparam int SZ_W = bfm_pkg::SZ_W;

  localparam logic [QW-1:0]  ONE        = QW'(1) << F;
  localparam logic [SQW-1:0] ONE_SQ     = SQW'(1) << (2 * F);
  localparam logic [SQW-1:0] TWO_ONE_SQ = SQW'(1) << (2 * F + 1);
  // r - ONE where r = floor(sqrt(2 * ONE^2))
  localparam longint unsigned R_ROOT = bfm_pkg::isqrt_const(64'd1 << (2 * F + 1));
  localparam logic [F-1:0]   K_DEN  = F'(R_ROOT - (64'd1 << F));

  // reciprocal of K_DEN: ceil(2^(3F-2) / K_DEN), below 2^(2F)
  localparam int KW = 3 * F + 1;
  localparam logic [KW-1:0] K_POW    = KW'(1) << (3 * F - 2);
  localparam logic [KW-1:0] K_MUL_W  = (K_POW + KW'(K_DEN) - KW'(1)) / KW'(K_DEN);
  localparam logic [F-1:0]  K_MUL_LO = K_MUL_W[F-1:0];
  localparam logic [F-1:0]  K_MUL_HI = K_MUL_W[2*F-1:F];

  // ---------------------------------------------------------------- config
  logic [SZ_W-1:0]            brush_size;
  logic [bfm_pkg::MODE_W-1:0] shape_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_size <= bfm_pkg::BRUSH_SIZE_RST;
      shape_mode <= bfm_pkg::SHAPE_MODE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bfm_pkg::REG_BRUSH_SIZE: brush_size <= cfg.data[SZ_W-1:0];
        bfm_pkg::REG_SHAPE_MODE: shape_mode <= cfg.data[bfm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic adv;
  logic out_valid;
  assign adv        = !out_valid || result.ready;
  assign item.ready = adv;

  // |2c - (size-1)|
  function automatic logic [SZ_W-1:0] centre_mag(logic [bfm_pkg::COORD_W-1:0] c,
                                                 logic [SZ_W-1:0] sz);
    logic [SZ_W:0] n;
    n = {1'b0, c, 1'b0} - {1'b0, sz} + (SZ_W + 1)'(1);
    return n[SZ_W] ? SZ_W'(-n) : n[SZ_W-1:0];
  endfunction

  // ---------------------------------------------------------------- stage 0
  logic [SZ_W-1:0] size_eff;
  logic            oor_c;

  assign size_eff = (32'(brush_size) > MAX_SIZE) ? SZ_W'(MAX_SIZE) : brush_size;
  assign oor_c    = (SZ_W'(item.col) >= size_eff) || (SZ_W'(item.row) >= size_eff);

  logic            s0_valid;
  bfm_pkg::tag_t   s0_tag;
  logic [SZ_W-1:0] s0_mx;
  logic [SZ_W-1:0] s0_my;
  logic [SZ_W-1:0] s0_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_tag.oor  <= oor_c;
      s0_tag.mode <= shape_mode;
      s0_mx       <= centre_mag(item.col, size_eff);
      s0_my       <= centre_mag(item.row, size_eff);
      s0_size     <= size_eff;
    end
  end

  // ---------------------------------------------------------------- normalise
  // round(mag * ONE / size): size/2 < ONE, so the rounding term just fills the low bits
  logic [NW1-1:0] num_x;
  logic [NW1-1:0] num_y;
  logic [F-1:0]   half_size;
  logic [SZ_W-1:0] den_size;

  assign half_size = F'(s0_size >> 1);
  assign num_x     = {s0_mx, half_size};
  assign num_y     = {s0_my, half_size};
  assign den_size  = (s0_size == '0) ? SZ_W'(1) : s0_size;

  logic          dx_valid;
  logic          dy_valid;
  logic [QW-1:0] ax;
  logic [QW-1:0] ay;
  bfm_pkg::tag_t dx_tag;
  bfm_pkg::tag_t dy_tag;

  bfm_div #(
    .NW (NW1),
    .DW (SZ_W),
    .QW (QW),
    .SBW($bits(bfm_pkg::tag_t))
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s0_valid),
    .num      (num_x),
    .den      (den_size),
    .sb_in    (s0_tag),
    .out_valid(dx_valid),
    .quo      (ax),
    .sb_out   (dx_tag)
  );

  bfm_div #(
    .NW (NW1),
    .DW (SZ_W),
    .QW (QW),
    .SBW($bits(bfm_pkg::tag_t))
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s0_valid),
    .num      (num_y),
    .den      (den_size),
    .sb_in    (s0_tag),
    .out_valid(dy_valid),
    .quo      (ay),
    .sb_out   (dy_tag)
  );

  // ---------------------------------------------------------------- squares, diamond test
  logic [SQW-1:0] ax_sq;
  logic [SQW-1:0] ay_sq;
  logic [QW:0]    a_sum;

  assign ax_sq = ax * ax;
  assign ay_sq = ay * ay;
  assign a_sum = {1'b0, ax} + {1'b0, ay};

  logic           m1_valid;
  bfm_pkg::ctag_t m1_tag;
  logic [SQW-1:0] m1_a2;
  logic [SQW-1:0] m1_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_tag.oor     <= dx_tag.oor;
      m1_tag.mode    <= dx_tag.mode;
      m1_tag.dia     <= (a_sum <= {1'b0, ONE});
      m1_tag.in_disc <= 1'b0;
      m1_a2          <= ax_sq;
      m1_b2          <= ay_sq;
    end
  end

  // ---------------------------------------------------------------- squared distance
  logic           m2_valid;
  bfm_pkg::ctag_t m2_tag;
  logic [SQW-1:0] m2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_tag <= m1_tag;
      m2_q   <= m1_a2 + m1_b2;
    end
  end

  // ---------------------------------------------------------------- disc test, radicand
  logic           m3_valid;
  bfm_pkg::ctag_t m3_tag;
  logic [SQW-1:0] m3_rad;
  logic           inside_c;

  assign inside_c = (m2_q <= ONE_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (adv) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_tag.oor     <= m2_tag.oor;
      m3_tag.mode    <= m2_tag.mode;
      m3_tag.dia     <= m2_tag.dia;
      m3_tag.in_disc <= inside_c;
      m3_rad         <= inside_c ? (TWO_ONE_SQ - m2_q) : '0;
    end
  end

  // ---------------------------------------------------------------- square root
  logic           sq_valid;
  logic [QW-1:0]  sq_root;
  bfm_pkg::ctag_t sq_tag;

  bfm_sqrt #(
    .VW (SQW),
    .RW (QW),
    .SBW($bits(bfm_pkg::ctag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (m3_valid),
    .rad      (m3_rad),
    .sb_in    (m3_tag),
    .out_valid(sq_valid),
    .root     (sq_root),
    .sb_out   (sq_tag)
  );

  // ---------------------------------------------------------------- s - ONE
  // outside the disc the radicand is zero, so the root falls below ONE here
  logic           p_valid;
  bfm_pkg::ctag_t p_tag;
  logic [F-1:0]   p_excess;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_tag    <= sq_tag;
      p_excess <= (sq_root > ONE) ? F'(sq_root - ONE) : '0;
    end
  end

  // ---------------------------------------------------------------- scale by 1/(r - ONE)
  // floor(x * ONE / K_DEN) = (x * K_MUL) >> (2F - 2), exact for x up to K_DEN;
  // the multiply is split into two F by F halves
  logic           cm_valid;
  bfm_pkg::ctag_t cm_tag;
  logic [2*F-1:0] cm_lo;
  logic [2*F-1:0] cm_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      cm_valid <= 1'b0;
    end else if (adv) begin
      cm_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm_tag <= p_tag;
      cm_lo  <= p_excess * K_MUL_LO;
      cm_hi  <= p_excess * K_MUL_HI;
    end
  end

  logic [3*F-1:0] cm_prod;
  logic [QW-1:0]  cw_quo;

  assign cm_prod = {cm_hi, {F{1'b0}}} + (3 * F)'(cm_lo);
  assign cw_quo  = cm_prod[2*F-2 +: QW];

  // ---------------------------------------------------------------- shape select, output register
  logic [QW-1:0] circle_w;
  logic [QW-1:0] weight_c;

  assign circle_w = (cw_quo > ONE) ? ONE : cw_quo;

  always_comb begin
    case (cm_tag.mode)
      bfm_pkg::SHAPE_CIRCLE:  weight_c = cm_tag.in_disc ? circle_w : '0;
      bfm_pkg::SHAPE_SQUARE:  weight_c = ONE;
      bfm_pkg::SHAPE_DIAMOND: weight_c = cm_tag.dia ? ONE : '0;
      default:                weight_c = '0;
    endcase
    if (cm_tag.oor) begin
      weight_c = '0;
    end
  end

  logic [QW-1:0] out_weight;
  logic          out_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_weight <= weight_c;
      out_oor    <= cm_tag.oor;
    end
  end

  assign result.valid        = out_valid;
  assign result.weight       = out_weight;
  assign result.out_of_range = out_oor;

  // ---------------------------------------------------------------- assertions
  // the two coordinate lanes stay in lock step
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (dx_valid == dy_valid) && (!dx_valid || (dx_tag == dy_tag)))
    else $error("coordinate divider lanes out of step");

  // a cell outside the grid always weighs nothing
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.out_of_range |-> result.weight == '0)
    else $error("out-of-range cell with non-zero weight");

  // weight never exceeds 1.0
  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.weight <= ONE)
    else $error("weight above one");

  // nothing is presented straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

@@ rtl/bfm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with valid and sideband.
`default_nettype none

module bfm_div #(
  parameter int NW  = 25,
  parameter int DW  = 9,
  parameter int QW  = 17,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [QW-1:0]  quo,
  output logic [SBW-1:0] sb_out
);

  // Compare width: holds both the partial remainder and the shifted divisor
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0]  rem_q [QW-1];
  logic [DW-1:0]  den_q [QW-1];
  logic [QW-1:0]  quo_q [QW];
  logic [SBW-1:0] sb_q  [QW];
  logic           vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0]  rem_i;
    logic [DW-1:0]  den_i;
    logic [QW-1:0]  quo_i;
    logic [SBW-1:0] sb_i;
    logic           vld_i;
    logic [CW-1:0]  trial;
    logic           take;

    // stage inputs
    if (k == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign quo_i = '0;
      assign sb_i  = sb_in;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign den_i = den_q[k-1];
      assign quo_i = quo_q[k-1];
      assign sb_i  = sb_q[k-1];
      assign vld_i = vld_q[k-1];
    end

    // try to subtract divisor shifted to this quotient bit
    assign trial = CW'(den_i) << B;
    assign take  = (CW'(rem_i) >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= take ? (quo_i | (QW'(1) << B)) : quo_i;
        sb_q[k]  <= sb_i;
      end
    end

    // remainder and divisor are not needed past the last bit
    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? NW'(CW'(rem_i) - trial) : rem_i;
          den_q[k] <= den_i;
        end
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quo       = quo_q[QW-1];
  assign sb_out    = sb_q[QW-1];

endmodule

`default_nettype wire

@@ rtl/bfm_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none

module bfm_sqrt #(
  parameter int VW  = 34,
  parameter int RW  = 17,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [VW-1:0]  rad,
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [RW-1:0]  root,
  output logic [SBW-1:0] sb_out
);

  localparam int CW = (VW > 2 * RW + 1) ? VW : 2 * RW + 1;

  logic [VW-1:0]  rem_q  [RW-1];
  logic [RW-1:0]  root_q [RW];
  logic [SBW-1:0] sb_q   [RW];
  logic           vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [VW-1:0]  rem_i;
    logic [RW-1:0]  root_i;
    logic [SBW-1:0] sb_i;
    logic           vld_i;
    logic [CW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_i  = rad;
      assign root_i = '0;
      assign sb_i   = sb_in;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign sb_i   = sb_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B); the two terms do not overlap
    assign trial = (CW'(root_i) << (B + 1)) | (CW'(1) << (2 * B));
    assign take  = (CW'(rem_i) >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= take ? (root_i | (RW'(1) << B)) : root_i;
        sb_q[k]   <= sb_i;
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? VW'(CW'(rem_i) - trial) : rem_i;
        end
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign root      = root_q[RW-1];
  assign sb_out    = sb_q[RW-1];

endmodule

`default_nettype wire
